/* rtl/brh_pkg.sv */
// Package: payload types, register indexes and size defaults of the bilinear heatmap resampler.
`timescale 1ns / 1ps
`default_nettype none
package brh_pkg;

  localparam int unsigned MaxColsDefault = 256;
  localparam int unsigned MaxRowsDefault = 64;

  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] RegColStep    = 2'd0;
  localparam logic [CfgIndexW-1:0] RegRowStep    = 2'd1;
  localparam logic [CfgIndexW-1:0] RegSourceCols = 2'd2;
  localparam logic [CfgIndexW-1:0] RegSourceRows = 2'd3;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpRender = 1'b1;

  typedef struct packed {
    logic               op;
    logic [7:0]         load_col;
    logic [5:0]         load_row;
    logic signed [15:0] sample;
    logic [11:0]        pixel_col;
    logic [11:0]        pixel_row;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] level;
  } out_beat_t;

endpackage
`default_nettype wire

/* rtl/bilinear_resample_heatmap.sv */
// Top level: bilinear resampler over a banked sample grid with a six-segment heat colormap.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | into      | in_valid_i / in_stall_o   | in_data_i  (in_beat_t)
//  out     | out of    | out_valid_o / out_stall_i | out_data_o (out_beat_t)
//  cfg     | into      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One beat enters per cycle while in_stall_o is low. A render beat passes the coordinate,
// address, blend (two multiply stages) and scale stages, then the output register.
// Load beats write the grid on the cycle they are taken and give no result.
// Reset clears valid bits and returns config registers to their defaults; the grid
// is undefined until loaded.
// An output register plus one skid entry part the two sides: input stalls only
// while the skid entry is full, and the whole pipe holds in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_resample_heatmap
  import brh_pkg::*;
#(
  parameter int unsigned MAX_COLS = MaxColsDefault,
  parameter int unsigned MAX_ROWS = MaxRowsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_beat_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_beat_t                 out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CH = (MAX_COLS + 1) / 2;
  localparam int unsigned RH = (MAX_ROWS + 1) / 2;
  localparam int unsigned BD = CH * RH;
  localparam int unsigned AW = (BD > 1) ? $clog2(BD) : 1;

  // config registers
  logic [23:0] col_step_q, row_step_q;
  logic [8:0]  src_cols_q;
  logic [6:0]  src_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_step_q <= 24'd65536;
      row_step_q <= 24'd65536;
      src_cols_q <= 9'd256;
      src_rows_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegColStep:    col_step_q <= cfg_data_i;
        RegRowStep:    row_step_q <= cfg_data_i;
        RegSourceCols: src_cols_q <= cfg_data_i[8:0];
        RegSourceRows: src_rows_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // last usable index: zero acts as one, oversize acts as the maximum
  logic [31:0] col_last, row_last;
  always_comb begin
    if (src_cols_q == 9'd0)                  col_last = 32'd0;
    else if (32'(src_cols_q) > MAX_COLS)     col_last = MAX_COLS - 1;
    else                                     col_last = 32'(src_cols_q) - 32'd1;
    if (src_rows_q == 7'd0)                  row_last = 32'd0;
    else if (32'(src_rows_q) > MAX_ROWS)     row_last = MAX_ROWS - 1;
    else                                     row_last = 32'(src_rows_q) - 32'd1;
  end

  // global advance: hold everything while the skid entry is occupied
  logic skid_v_q, out_v_q;
  logic en;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  logic in_fire;
  assign in_fire = in_valid_i && en;

  // stage 1: source coordinates
  logic        v1_q;
  logic [35:0] xs_q, ys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_fire && (in_data_i.op == OpRender);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xs_q <= 36'(in_data_i.pixel_col) * 36'(col_step_q);
      ys_q <= 36'(in_data_i.pixel_row) * 36'(row_step_q);
    end
  end

  // load write: four banks split by column and row parity
  logic          ld_ok;
  logic [1:0]    ld_bank;
  logic [AW-1:0] ld_addr;
  assign ld_ok   = in_fire && (in_data_i.op == OpLoad) &&
                   (32'(in_data_i.load_col) < MAX_COLS) &&
                   (32'(in_data_i.load_row) < MAX_ROWS);
  assign ld_bank = {in_data_i.load_col[0], in_data_i.load_row[0]};
  assign ld_addr = AW'(32'(in_data_i.load_col[7:1]) * RH + 32'(in_data_i.load_row[5:1]));

  // stage 2 address: clamp both neighbours to the last row or column
  logic [19:0] xi, yi;
  logic [CW-1:0] x0, x1;
  logic [RW-1:0] y0, y1;
  assign xi = xs_q[35:16];
  assign yi = ys_q[35:16];

  always_comb begin
    x0 = (32'(xi) < col_last)          ? CW'(xi)          : CW'(col_last);
    x1 = (32'(xi) + 32'd1 < col_last)  ? CW'(32'(xi) + 1) : CW'(col_last);
    y0 = (32'(yi) < row_last)          ? RW'(yi)          : RW'(row_last);
    y1 = (32'(yi) + 32'd1 < row_last)  ? RW'(32'(yi) + 1) : RW'(row_last);
  end

  logic [AW-1:0] rd_addr [4];
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [CW-1:0] cs;
      logic [RW-1:0] rs;
      cs = (x0[0] == b[1]) ? x0 : x1;
      rs = (y0[0] == b[0]) ? y0 : y1;
      rd_addr[b] = AW'(32'(cs >> 1) * RH + 32'(rs >> 1));
    end
  end

  logic [15:0] rd_q [4];
  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [15:0] mem [BD];
    always_ff @(posedge clk_i) begin
      if (ld_ok && ld_bank == 2'(g)) mem[ld_addr] <= in_data_i.sample;
    end
    always_ff @(posedge clk_i) begin
      if (en) rd_q[g] <= mem[rd_addr[g]];
    end
  end

  logic        v2_q;
  logic        xp0_q, xp1_q, yp0_q, yp1_q;
  logic [15:0] xf2_q, yf2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp0_q <= x0[0];
      xp1_q <= (x0 == x1) ? x0[0] : ~x0[0];
      yp0_q <= y0[0];
      yp1_q <= (y0 == y1) ? y0[0] : ~y0[0];
      xf2_q <= xs_q[15:0];
      yf2_q <= ys_q[15:0];
    end
  end

  // stage 3: row blend
  logic signed [15:0] s00, s01, s10, s11;
  assign s00 = rd_q[{xp0_q, yp0_q}];
  assign s01 = rd_q[{xp0_q, yp1_q}];
  assign s10 = rd_q[{xp1_q, yp0_q}];
  assign s11 = rd_q[{xp1_q, yp1_q}];

  logic signed [17:0] yf_s, yw_s;
  assign yf_s = $signed({2'b00, yf2_q});
  assign yw_s = 18'sd65536 - yf_s;

  logic               v3_q;
  logic signed [33:0] ra_q, rb_q;
  logic [15:0]        xf3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q  <= 34'(s00 * yw_s) + 34'(s01 * yf_s);
      rb_q  <= 34'(s10 * yw_s) + 34'(s11 * yf_s);
      xf3_q <= xf2_q;
    end
  end

  // stage 4: column blend
  logic signed [17:0] xf_s, xw_s;
  assign xf_s = $signed({2'b00, xf3_q});
  assign xw_s = 18'sd65536 - xf_s;

  logic               v4_q;
  logic signed [50:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) acc_q <= 51'(ra_q * xw_s) + 51'(rb_q * xf_s);
  end

  // stage 5: round, saturate, scale for the colormap
  logic signed [50:0] rsum;
  logic signed [18:0] lvl_w;
  logic signed [15:0] lvl;
  logic [12:0]        vcl;
  logic [15:0]        c6;
  assign rsum  = acc_q + 51'sd2147483648;
  assign lvl_w = 19'(rsum >>> 32);
  always_comb begin
    if (lvl_w > 19'sd32767)       lvl = 16'sh7fff;
    else if (lvl_w < -19'sd32768) lvl = 16'sh8000;
    else                          lvl = 16'(lvl_w);
    if (lvl < 16'sd0)             vcl = 13'd0;
    else if (lvl > 16'sd4096)     vcl = 13'd4096;
    else                          vcl = 13'(lvl);
    c6 = 16'(vcl) * 16'd6;
  end

  logic               v5_q;
  logic signed [15:0] lvl5_q;
  logic [2:0]         hi5_q;
  logic [11:0]        fr5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lvl5_q <= lvl;
      hi5_q  <= c6[14:12];
      fr5_q  <= c6[11:0];
    end
  end

  // stage 6: segment select
  logic [19:0] f255;
  logic [7:0]  f;
  out_beat_t   pd;
  assign f255 = {fr5_q, 8'd0} - 20'(fr5_q);
  assign f    = f255[19:12];

  always_comb begin
    pd.level = lvl5_q;
    unique case (hi5_q)
      3'd0:    begin pd.red = 8'd0;   pd.green = 8'd0;      pd.blue = f;          end
      3'd1:    begin pd.red = 8'd0;   pd.green = f;         pd.blue = 8'd255;     end
      3'd2:    begin pd.red = 8'd0;   pd.green = 8'd255;    pd.blue = 8'd255 - f; end
      3'd3:    begin pd.red = f;      pd.green = 8'd255;    pd.blue = 8'd0;       end
      3'd4:    begin pd.red = 8'd255; pd.green = 8'd255 - f; pd.blue = 8'd0;      end
      3'd5:    begin pd.red = 8'd255; pd.green = f;         pd.blue = f;          end
      default: begin pd.red = 8'd255; pd.green = 8'd255;    pd.blue = 8'd255;     end
    endcase
  end

  // output register and skid entry
  out_beat_t out_q, skid_q;
  logic      out_fire;
  assign out_fire = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) skid_v_q <= 1'b0;
    end else if (v5_q) begin
      if (out_v_q && !out_fire) skid_v_q <= 1'b1;
      else                      out_v_q  <= 1'b1;
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (v5_q) begin
      if (out_v_q && !out_fire) skid_q <= pd;
      else                      out_q  <= pd;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // a filled skid entry always sits behind a shown result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry without output beat");

  // a refused result is still offered next cycle
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> out_v_q) else $error("stalled result dropped");

  // a frozen pipe keeps its last stage
  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_stall_i) |=> ($stable(v5_q) && skid_v_q))
    else $error("pipe moved while held");

endmodule
`default_nettype wire

/* test/bilinear_resample_heatmap_tb.sv */
// Testbench for the bilinear heatmap resampler: directed table, then random load/render beats.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_resample_heatmap_tb;
  import brh_pkg::*;

  localparam int unsigned GridCols = MaxColsDefault;
  localparam int unsigned GridRows = MaxRowsDefault;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_beat_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_beat_t            out_data_o;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  bilinear_resample_heatmap u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the grid (updated on accepted load beats) and of the registers (set_config).
  logic signed [15:0] grid_mem [GridCols*GridRows];
  bit                 grid_written [GridCols*GridRows];
  logic [23:0]        col_step_q, row_step_q;
  logic [8:0]         source_cols_q;
  logic [6:0]         source_rows_q;

  out_beat_t pixel_q [$];
  int        mismatches = 0;
  int        src_idle = 0;
  int        snk_idle = 0;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned eff_size(input int unsigned reg_val, input int unsigned maxv);
    if (reg_val == 0) return 1;
    if (reg_val > maxv) return maxv;
    return reg_val;
  endfunction

  // Four neighbour indexes of a destination pixel, with far-edge clamping.
  function automatic void neighbours(input logic [11:0] pc, input logic [11:0] pr,
                                     output int x0, output int x1, output int y0,
                                     output int y1, output longint xf, output longint yf);
    longint unsigned xs, ys, xi, yi, cols, rows;
    cols = eff_size(source_cols_q, GridCols);
    rows = eff_size(source_rows_q, GridRows);
    xs = longint'(pc) * longint'(col_step_q);
    ys = longint'(pr) * longint'(row_step_q);
    xi = xs >> 16;
    yi = ys >> 16;
    xf = longint'(xs & 64'hFFFF);
    yf = longint'(ys & 64'hFFFF);
    x0 = (xi < cols - 1) ? int'(xi) : int'(cols - 1);
    x1 = (xi + 1 < cols - 1) ? int'(xi + 1) : int'(cols - 1);
    y0 = (yi < rows - 1) ? int'(yi) : int'(rows - 1);
    y1 = (yi + 1 < rows - 1) ? int'(yi + 1) : int'(rows - 1);
  endfunction

  // First grid entry a render would read before it was loaded; -1 if none.
  function automatic int first_unloaded(input logic [11:0] pc, input logic [11:0] pr);
    int x0, x1, y0, y1;
    longint xf, yf;
    neighbours(pc, pr, x0, x1, y0, y1, xf, yf);
    if (!grid_written[x0*GridRows+y0]) return x0*GridRows+y0;
    if (!grid_written[x0*GridRows+y1]) return x0*GridRows+y1;
    if (!grid_written[x1*GridRows+y0]) return x1*GridRows+y0;
    if (!grid_written[x1*GridRows+y1]) return x1*GridRows+y1;
    return -1;
  endfunction

  function automatic out_beat_t blend_pixel(input logic [11:0] pc, input logic [11:0] pr);
    int x0, x1, y0, y1;
    longint xf, yf, a, b, acc, lvl, v, c, hi, f;
    out_beat_t o;
    neighbours(pc, pr, x0, x1, y0, y1, xf, yf);
    a = longint'(grid_mem[x0*GridRows+y0]) * (65536 - yf)
      + longint'(grid_mem[x0*GridRows+y1]) * yf;
    b = longint'(grid_mem[x1*GridRows+y0]) * (65536 - yf)
      + longint'(grid_mem[x1*GridRows+y1]) * yf;
    acc = a * (65536 - xf) + b * xf;
    // Round half up, then floor by arithmetic shift.
    lvl = (acc + 64'sd2147483648) >>> 32;
    if (lvl > 32767) lvl = 32767;
    if (lvl < -32768) lvl = -32768;
    v = (lvl < 0) ? 0 : ((lvl > 4096) ? 4096 : lvl);
    c = v * 6;
    hi = c >>> 12;
    f = ((c & 4095) * 255) >>> 12;
    case (hi)
      0: begin o.red = 0; o.green = 0; o.blue = f[7:0]; end
      1: begin o.red = 0; o.green = f[7:0]; o.blue = 255; end
      2: begin o.red = 0; o.green = 255; o.blue = 8'(255 - f); end
      3: begin o.red = f[7:0]; o.green = 255; o.blue = 0; end
      4: begin o.red = 255; o.green = 8'(255 - f); o.blue = 0; end
      5: begin o.red = 255; o.green = f[7:0]; o.blue = f[7:0]; end
      default: begin o.red = 255; o.green = 255; o.blue = 255; end
    endcase
    o.level = lvl[15:0];
    return o;
  endfunction

  // Drive one beat with random idle before it; update the shadow state on acceptance.
  // Called and returns at a falling edge.
  task automatic drive_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (b.op == OpLoad) begin
      grid_mem[b.load_col*GridRows+b.load_row]     = b.sample;
      grid_written[b.load_col*GridRows+b.load_row] = 1'b1;
    end else begin
      pixel_q.push_back(typed ? want : blend_pixel(b.pixel_col, b.pixel_row));
    end
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    // Let in-flight renders clear the pipe before touching registers.
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [23:0] cs, input logic [23:0] rs,
                            input logic [8:0] nc, input logic [6:0] nr);
    logic [23:0] vals [4];
    vals = '{cs, rs, 24'(nc), 24'(nr)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CfgIndexW'(i);
      cfg_data_i  <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    col_step_q    = cs;
    row_step_q    = rs;
    source_cols_q = nc;
    source_rows_q = nr;
  endtask

  function automatic in_beat_t load_beat(input int c, input int r, input logic [15:0] s);
    in_beat_t b;
    b = '0;
    b.op = OpLoad;
    b.load_col = c[7:0];
    b.load_row = r[5:0];
    b.sample = s;
    return b;
  endfunction

  function automatic void add_load(input int c, input int r, input logic [15:0] s);
    dir_rows.push_back('{load_beat(c, r, s), 1'b0, '0});
  endfunction

  function automatic void add_render(input int pc, input int pr, input bit typed,
                                     input int red, input int grn, input int blu,
                                     input int lvl);
    in_beat_t b;
    out_beat_t o;
    b = '0;
    b.op = OpRender;
    b.pixel_col = pc[11:0];
    b.pixel_row = pr[11:0];
    o = '{red[7:0], grn[7:0], blu[7:0], lvl[15:0]};
    dir_rows.push_back('{b, typed, o});
  endfunction

  // Receiver: stall at random, check each result beat against the oldest expectation.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < snk_idle);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        out_beat_t w;
        w = pixel_q.pop_front();
        if (out_data_o.red !== w.red)
          report($sformatf("red %0d, want %0d", out_data_o.red, w.red));
        if (out_data_o.green !== w.green)
          report($sformatf("green %0d, want %0d", out_data_o.green, w.green));
        if (out_data_o.blue !== w.blue)
          report($sformatf("blue %0d, want %0d", out_data_o.blue, w.blue));
        if (out_data_o.level !== w.level)
          report($sformatf("level %0d, want %0d", out_data_o.level, w.level));
      end
    end
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [23:0] cs_tab [6];
    logic [23:0] rs_tab [6];
    logic [8:0]  nc_tab [6];
    logic [6:0]  nr_tab [6];
    in_beat_t b;
    int miss, cols, rows;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= RegColStep;
    cfg_data_i  <= '0;
    col_step_q    = 24'd65536;
    row_step_q    = 24'd65536;
    source_cols_q = 9'd256;
    source_rows_q = 7'd64;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table under reset registers: unit steps, full grid size.
    add_load(0, 0, 16'sd4096);
    add_load(0, 1, 16'sd4096);
    add_load(1, 0, 16'sd4096);
    add_load(1, 1, 16'sd4096);
    add_render(0, 0, 1, 255, 255, 255, 4096);
    add_load(0, 0, 16'sd0);
    add_render(0, 0, 1, 0, 0, 0, 0);
    add_load(0, 0, -16'sd32768);
    add_render(0, 0, 1, 0, 0, 0, -32768);
    add_load(0, 0, 16'sd32767);
    add_render(0, 0, 1, 255, 255, 255, 32767);
    add_load(0, 0, 16'sd1000);
    add_render(0, 0, 0, 0, 0, 0, 0);
    // Far edge: both neighbours clamp onto the last column and row.
    add_load(255, 63, 16'sd2048);
    add_render(4095, 4095, 1, 0, 255, 0, 2048);
    add_load(255, 63, 16'sd3500);
    add_render(4095, 4095, 0, 0, 0, 0, 0);
    foreach (dir_rows[i]) drive_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // Register settings: reset values, zeros, all-ones, fractional steps, odd sizes.
    cs_tab = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd32768, 24'd12345, 24'd200000};
    rs_tab = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd16384, 24'd54321, 24'd98304};
    nc_tab = '{9'd256, 9'd0, 9'd511, 9'd16, 9'd200, 9'd1};
    nr_tab = '{7'd64, 7'd0, 7'd127, 7'd8, 7'd40, 7'd64};

    for (int ph = 0; ph < 6; ph++) begin
      set_config(cs_tab[ph], rs_tab[ph], nc_tab[ph], nr_tab[ph]);
      // Two phases each: sender light/receiver heavy, then swapped, then no idling.
      if (ph < 2) begin
        src_idle = 13; snk_idle = 69;
      end else if (ph < 4) begin
        src_idle = 69; snk_idle = 13;
      end else begin
        src_idle = 0; snk_idle = 0;
      end
      cols = eff_size(source_cols_q, GridCols);
      rows = eff_size(source_rows_q, GridRows);
      for (int n = 0; n < 90; n++) begin
        b = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom}));
        if ($urandom_range(0, 99) < 35) begin
          b.op = OpLoad;
          if ($urandom_range(0, 3) != 0) begin
            b.load_col = 8'($urandom_range(0, cols - 1));
            b.load_row = 6'($urandom_range(0, rows - 1));
          end
        end else begin
          b.op = OpRender;
          case ($urandom_range(0, 3))
            0, 1: begin
              b.pixel_col = 12'($urandom_range(0, 63));
              b.pixel_row = 12'($urandom_range(0, 63));
            end
            2: begin
              b.pixel_col = 12'($urandom_range(0, 7));
              b.pixel_row = 12'($urandom_range(0, 7));
            end
            default: ;
          endcase
          // Fill the grid entry first rather than read an unloaded one.
          miss = first_unloaded(b.pixel_col, b.pixel_row);
          if (miss >= 0) begin
            b.op = OpLoad;
            b.load_col = 8'(miss / GridRows);
            b.load_row = 6'(miss % GridRows);
          end
        end
        drive_beat(b, 1'b0, '0);
        // Hold off once until every pending result has come back.
        if (ph == 1 && n == 45) begin
          in_valid_i <= 1'b0;
          while (pixel_q.size() != 0) @(negedge clk_i);
        end
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
